// ===== src/est_pkg.sv =====
// ----------------------------------------------------------------------------
// est_pkg
// Types and constants for the event slot table, including its slot memory entry.
// ----------------------------------------------------------------------------
package est_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ActW    = 6;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NO_EMPTY  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_SCAN = 2'd1,
    FSM_DONE = 2'd2
  } fsm_e;

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic [7:0]         kind;
    logic [7:0]         ctx;
    logic [15:0]        key;
    logic [15:0]        option;
    logic signed [31:0] stamp;
  } slot_t;

endpackage

// ===== src/est_ram.sv =====
// ----------------------------------------------------------------------------
// est_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module est_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/event_slot_table.sv =====
// ----------------------------------------------------------------------------
// event_slot_table
// Table of event slots: add into the lowest empty slot, remove the lowest
// slot matching key and option, clear all. One result word per command.
// Add and remove scan the slot memory through its read port, one entry per
// cycle from slot 0, until a hit or until active_slots entries are read; add on
// a full table, clear and the unused opcode go straight to the result word.
// One command at a time: the next word is taken at the edge after the result
// has been loaded into the output register. Reset empties every slot at once
// through per-slot valid flags and sets active_slots to min(SLOTS, 32).
// ----------------------------------------------------------------------------
module event_slot_table #(
  parameter int unsigned SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: active_slots.
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // Command stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: kind[7:0], context_req[15:8], event_key[31:16],
  // option[47:32], stamp[79:48].
  input  logic [79:0] s_axis_tdata,
  // From bit 0: opcode[1:0].
  input  logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: status[1:0], slot[6:2], free_slots[12:7], zero pad[15:13].
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = ((AW + 1) > est_pkg::ActW) ? (AW + 1) : est_pkg::ActW;
  localparam logic [est_pkg::ActW-1:0] ActReset = est_pkg::ActW'((SLOTS < 32) ? SLOTS : 32);

  // Control state.
  est_pkg::fsm_e            state_q, state_d;
  logic [CntW-1:0]          idx_q;
  logic                     pend_q;
  logic [SLOTS-1:0]         valid_q;
  logic [est_pkg::ActW-1:0] occ_q;
  logic [est_pkg::ActW-1:0] act_q;
  logic                     m_valid_q;

  // Payload registers.
  est_pkg::op_e             req_op_q;
  est_pkg::slot_t           req_q;
  logic [AW-1:0]            pidx_q;
  logic                     rd_vld_q;
  est_pkg::status_e         res_status_q;
  logic [est_pkg::SlotW-1:0] res_slot_q;
  logic [15:0]              m_data_q;

  // Combinational signals.
  logic                     in_acc;
  logic                     cfg_ok;
  logic                     rd_en;
  logic                     wr_en;
  est_pkg::slot_t           in_slot;
  est_pkg::slot_t           rdata;
  logic [7:0]               rd_kind;
  logic [15:0]              rd_key;
  logic [15:0]              rd_opt;
  logic                     cand;
  logic                     hit;
  logic                     miss;
  logic                     out_load;
  logic                     full;
  logic                     new_occ;
  logic                     old_occ;
  logic [est_pkg::ActW-1:0] free_now;

  assign in_slot.kind   = s_axis_tdata[7:0];
  assign in_slot.ctx    = s_axis_tdata[15:8];
  assign in_slot.key    = s_axis_tdata[31:16];
  assign in_slot.option = s_axis_tdata[47:32];
  assign in_slot.stamp  = s_axis_tdata[79:48];

  assign cfg_ok = cfg_we_i && (cfg_wdata_i != '0) && (int'(cfg_wdata_i) <= int'(SLOTS));
  assign full   = (occ_q == act_q);
  assign free_now = act_q - occ_q;

  // Output and datapath control.
  always_comb begin
    in_acc   = 1'b0;
    rd_en    = 1'b0;
    hit      = 1'b0;
    miss     = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    // A slot never written, or emptied since, reads as zero kind, key and option.
    rd_kind  = rd_vld_q ? rdata.kind : 8'd0;
    rd_key   = rd_vld_q ? rdata.key : 16'd0;
    rd_opt   = rd_vld_q ? rdata.option : 16'd0;
    new_occ  = (req_q.kind != 8'd0) && (req_q.key != 16'd0);
    old_occ  = (rd_kind != 8'd0) && (rd_key != 16'd0);
    if (req_op_q == est_pkg::OP_ADD) begin
      cand = (rd_kind == 8'd0) && (rd_key == 16'd0);
    end else begin
      cand = (rd_key == req_q.key) && (rd_opt == req_q.option);
    end
    case (state_q)
      est_pkg::FSM_IDLE: begin
        in_acc = s_axis_tvalid;
      end
      est_pkg::FSM_SCAN: begin
        rd_en = (idx_q < CntW'(act_q));
        hit   = pend_q && cand;
        miss  = !pend_q && !rd_en;
        wr_en = hit && (req_op_q == est_pkg::OP_ADD);
      end
      est_pkg::FSM_DONE: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
        in_acc = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      est_pkg::FSM_IDLE: begin
        if (s_axis_tvalid) begin
          if ((est_pkg::op_e'(s_axis_tuser) == est_pkg::OP_REMOVE) ||
              ((est_pkg::op_e'(s_axis_tuser) == est_pkg::OP_ADD) && !full)) begin
            state_d = est_pkg::FSM_SCAN;
          end else begin
            state_d = est_pkg::FSM_DONE;
          end
        end
      end
      est_pkg::FSM_SCAN: begin
        if (hit || miss) begin
          state_d = est_pkg::FSM_DONE;
        end
      end
      est_pkg::FSM_DONE: begin
        if (out_load) begin
          state_d = est_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = est_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= est_pkg::FSM_IDLE;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      valid_q   <= '0;
      occ_q     <= '0;
      act_q     <= ActReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= rd_en;
      if (in_acc) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cfg_ok) begin
        act_q   <= cfg_wdata_i;
        valid_q <= '0;
        occ_q   <= '0;
      end else if (in_acc && (est_pkg::op_e'(s_axis_tuser) == est_pkg::OP_CLEAR)) begin
        valid_q <= '0;
        occ_q   <= '0;
      end else if (hit) begin
        if (req_op_q == est_pkg::OP_ADD) begin
          valid_q[pidx_q] <= 1'b1;
          occ_q <= occ_q + est_pkg::ActW'(new_occ);
        end else begin
          valid_q[pidx_q] <= 1'b0;
          occ_q <= occ_q - est_pkg::ActW'(old_occ);
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_op_q   <= est_pkg::op_e'(s_axis_tuser);
      req_q      <= in_slot;
      res_slot_q <= '0;
      if ((est_pkg::op_e'(s_axis_tuser) == est_pkg::OP_ADD) && full) begin
        res_status_q <= est_pkg::ST_FULL;
      end else begin
        res_status_q <= est_pkg::ST_OK;
      end
    end else if (hit) begin
      res_status_q <= est_pkg::ST_OK;
      res_slot_q   <= est_pkg::SlotW'(pidx_q);
    end else if (miss) begin
      res_slot_q <= '0;
      if (req_op_q == est_pkg::OP_ADD) begin
        res_status_q <= est_pkg::ST_NO_EMPTY;
      end else begin
        res_status_q <= est_pkg::ST_NOT_FOUND;
      end
    end
    if (rd_en) begin
      pidx_q   <= idx_q[AW-1:0];
      rd_vld_q <= valid_q[idx_q[AW-1:0]];
    end
    if (out_load) begin
      m_data_q <= {3'b000, free_now, res_slot_q, res_status_q};
    end
  end

  est_ram #(
    .Width ($bits(est_pkg::slot_t)),
    .Depth (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (pidx_q),
    .wdata_i (req_q),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign s_axis_tready = (state_q == est_pkg::FSM_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // The occupied count can never pass the number of slots in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= act_q)
    else $error("occupied count exceeds active slots");

  // The slot memory is written only for a comparison that has just found its slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> (pend_q && hit))
    else $error("slot write without a pending hit");

  // A command word always leaves the idle state on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != est_pkg::FSM_IDLE))
    else $error("command accepted but no work started");

  // A finished result waits while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == est_pkg::FSM_DONE) && m_valid_q && !m_axis_tready)
      |=> (state_q == est_pkg::FSM_DONE))
    else $error("result dropped while output busy");

endmodule
